// ----- design/fp23_add_sub_macros.svh -----
// Assertion macros for the fp23 adder and subtractor checker.
// Needs nothing else; included by the checker file.
`ifndef FP23_ADD_SUB_MACROS_SVH
`define FP23_ADD_SUB_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define FP23_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition that must hold on every clock edge outside reset.
`define FP23_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

`endif

// ----- design/fp23as_pkg.sv -----
// Shared constants for the fp23 adder and subtractor.
// No dependencies; imported by the top level and its checker.
package fp23as_pkg;
   localparam int EXP_W = 6;
   localparam int MAN_W = 16;
   localparam int FRAC_W = MAN_W + 1;
   localparam int GAP_MAX = MAN_W;
   localparam logic [4:0] CANCEL_SHIFT = 5'd31;
   localparam logic ACTION_SUB = 1'b0;
   localparam logic ACTION_ADD = 1'b1;
endpackage

// ----- design/fp23_add_sub.sv -----
// fp23_add_sub: adds or subtracts two 23-bit floats (sign, 6-bit exponent,
// 16-bit fraction). An input register feeds one pass of align, add and
// normalize logic into the result register.
// Throughput is one word per cycle; busy is never raised and the receiver
// cannot stall. Synchronous active-high reset clears the valid flags only.
module fp23_add_sub
   import fp23as_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic             req_a_sign,
   input  logic [EXP_W-1:0] req_a_exp,
   input  logic [MAN_W-1:0] req_a_man,
   input  logic             req_b_sign,
   input  logic [EXP_W-1:0] req_b_exp,
   input  logic [MAN_W-1:0] req_b_man,
   input  logic             req_action,
   output logic             rsp_valid,
   output logic             rsp_sign,
   output logic [EXP_W-1:0] rsp_exp,
   output logic [MAN_W-1:0] rsp_man
);
   logic             vld_ff;
   logic             as_ff, bs_ff, act_ff;
   logic [EXP_W-1:0] ae_ff, be_ff;
   logic [MAN_W-1:0] am_ff, bm_ff;
   logic             out_vld_ff;
   logic             sign_ff, sign_in;
   logic [EXP_W-1:0] exp_ff, exp_in;
   logic [MAN_W-1:0] man_ff, man_in;

   logic              bs_eff, swap, ls, ss;
   logic [EXP_W-1:0]  le, se, d;
   logic [FRAC_W-1:0] lm, sm;
   logic [33:0]       big, lesser, total;
   logic [FRAC_W-1:0] sum;
   logic [4:0]        shift;
   logic              found;
   logic [FRAC_W-1:0] shifted;
   logic [EXP_W:0]    e;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         vld_ff <= start;
         out_vld_ff <= vld_ff;
      end
      as_ff <= req_a_sign;
      ae_ff <= req_a_exp;
      am_ff <= req_a_man;
      bs_ff <= req_b_sign;
      be_ff <= req_b_exp;
      bm_ff <= req_b_man;
      act_ff <= req_action;
      sign_ff <= sign_in;
      exp_ff <= exp_in;
      man_ff <= man_in;
   end

   always_comb begin
      bs_eff = (act_ff == ACTION_SUB) ? ~bs_ff : bs_ff;
      swap = {ae_ff, am_ff} < {be_ff, bm_ff};
      ls = swap ? bs_eff : as_ff;
      ss = swap ? as_ff : bs_eff;
      le = swap ? be_ff : ae_ff;
      se = swap ? ae_ff : be_ff;
      lm = {le != '0, swap ? bm_ff : am_ff};
      sm = {se != '0, swap ? am_ff : bm_ff};
      d = le - se;
      big = {1'b0, lm, {MAN_W{1'b0}}};
      // Alignment truncates; a gap beyond the fraction width drops S.
      lesser = (d <= EXP_W'(GAP_MAX)) ? ({1'b0, sm, {MAN_W{1'b0}}} >> d) : '0;
      total = (ls ^ ss) ? (big - lesser) : (big + lesser);
      sum = total[33:FRAC_W];
      // Leading-one search over sum bits 16..1; bit 0 never counts.
      found = 1'b0;
      shift = CANCEL_SHIFT;
      for (int i = 1; i <= MAN_W; i++) begin
         if (sum[i]) begin
            found = 1'b1;
            shift = 5'(MAN_W - i);
         end
      end
      shifted = sum << shift[3:0];
      man_in = found ? shifted[MAN_W-1:0] : '0;
      e = {1'b0, le} - {2'b00, shift};
      exp_in = e[EXP_W] ? '0 : (e[EXP_W-1:0] + 1'b1);
      sign_in = ls;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_sign = sign_ff;
   assign rsp_exp = exp_ff;
   assign rsp_man = man_ff;
endmodule

// ----- design/fp23_add_sub_checker.sv -----
// Port-level checker for fp23_add_sub, attached by the bind below.
// Depends on fp23as_pkg and fp23_add_sub_macros.svh.
`include "fp23_add_sub_macros.svh"

module fp23as_checker
   import fp23as_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input logic [EXP_W-1:0] rsp_exp
);
   `FP23_ASSERT_ALWAYS(a_never_busy, clock, reset, !busy, "busy raised")
   `FP23_ASSERT_IMPL(a_word_returns, clock, reset, start && !busy, ##2 rsp_valid, "word lost")
   `FP23_ASSERT_IMPL(a_no_stray, clock, reset, !start, ##2 !rsp_valid, "stray result")
   `FP23_ASSERT_IMPL(a_exp_known, clock, reset, rsp_valid, !$isunknown(rsp_exp), "exp unknown")
endmodule

bind fp23_add_sub fp23as_checker u_fp23as_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_exp(rsp_exp)
);
